// File: rtl/tld_pkg.sv
// Package for the terminal line discipline: sizes, character and result codes,
// and the request and result structs. No dependencies.
`default_nettype none
package tld_pkg;

  localparam int LINE_DEPTH = 128;
  localparam int RING_DEPTH = 256;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int LINE_LW    = LINE_AW + 1;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int CFG_IW     = 2;

  localparam logic [1:0] KIND_KEY     = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_DISCARD = 2'd2;

  localparam logic [1:0] ECHO_NONE  = 2'd0;
  localparam logic [1:0] ECHO_BYTE  = 2'd1;
  localparam logic [1:0] ECHO_NL    = 2'd2;
  localparam logic [1:0] ECHO_ERASE = 2'd3;

  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_INT  = 2'd1;
  localparam logic [1:0] SIG_STOP = 2'd2;

  localparam logic [CFG_IW-1:0] CFG_ECHO  = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] CFG_CANON = CFG_IW'(1);

  localparam logic [7:0] CH_ETX   = 8'd3;
  localparam logic [7:0] CH_EOT   = 8'd4;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NAK   = 8'd21;
  localparam logic [7:0] CH_SUB   = 8'd26;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'd127;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] key_byte;
  } tld_req_t;

  typedef struct packed {
    logic [1:0] echo_kind;
    logic [7:0] echo_byte;
    logic [6:0] erase_count;
    logic [1:0] signal_kind;
    logic       delivery_dropped;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       line_end;
    logic       end_of_input;
    logic       ring_empty;
  } tld_rsp_t;

endpackage
`default_nettype wire

// File: rtl/terminal_line_discipline_core.sv
// Terminal line discipline top level: sequencer, pointers, line and ring RAMs.
// Depends on tld_pkg and tld_ram.
//
// Usage: requests come in on req (kind, key_byte) with req_valid/req_stall;
// each request gives exactly one result on rsp with rsp_valid/rsp_stall.
// Configuration writes (echo_enable index 0, canonical_mode index 1) use
// cfg_valid/cfg_ready and are taken in any cycle; write only while idle.
// Key requests that deliver no line, discard and read-on-empty requests go
// from S_IDLE to S_EMIT, which loads the result into the output register;
// a read that pops a byte passes through S_READ first (one ring RAM read).
// A line delivery (CR, LF or Ctrl-D) copies one byte per cycle from the
// line RAM into the ring RAM in S_DLV before S_EMIT. One request is worked
// on at a time; the next one is taken as soon as the previous result sits
// in the output register.
// Reset: line and ring empty, echo on, canonical mode on. RAM contents are
// not cleared and no clearing pass is run.
// A stalled result holds in the output register; a finished request waits
// for that register to free up before the next result is loaded.
`default_nettype none
module terminal_line_discipline_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire tld_pkg::tld_req_t             req,
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output tld_pkg::tld_rsp_t                  rsp,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tld_pkg::CFG_IW-1:0]    cfg_index,
  input  wire logic                          cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_DLV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;
  tld_pkg::tld_rsp_t res, res_next;
  logic echo_enable, echo_enable_next;
  logic canonical_mode, canonical_mode_next;
  logic end_pending, end_pending_next;
  logic [tld_pkg::LINE_AW-1:0] line_count, line_count_next;
  logic [tld_pkg::LINE_LW-1:0] dlen, dlen_next;
  logic [tld_pkg::LINE_LW-1:0] idx, idx_next;
  logic pv, pv_next;
  logic [tld_pkg::RING_AW-1:0] wp, wp_next;
  logic [tld_pkg::RING_AW-1:0] rp, rp_next;

  logic                        line_we;
  logic [tld_pkg::LINE_AW-1:0] line_waddr;
  logic [7:0]                  line_wdata;
  logic [7:0]                  line_rdata;
  logic                        ring_we;
  logic [7:0]                  ring_wdata;
  logic [7:0]                  ring_rdata;
  logic                        ring_full;
  logic                        accept;

  function automatic logic [tld_pkg::RING_AW-1:0] ptr_inc(
    input logic [tld_pkg::RING_AW-1:0] p
  );
    if (32'(p) == tld_pkg::RING_DEPTH - 1) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  function automatic logic [6:0] erase_sat(input logic [tld_pkg::LINE_AW-1:0] c);
    if (32'(c) > 32'd127) begin
      return 7'd127;
    end
    return 7'(c);
  endfunction

  tld_ram #(.DEPTH(tld_pkg::LINE_DEPTH), .WIDTH(8)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .raddr (idx[tld_pkg::LINE_AW-1:0]),
    .rdata (line_rdata)
  );

  tld_ram #(.DEPTH(tld_pkg::RING_DEPTH), .WIDTH(8)) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wp),
    .wdata (ring_wdata),
    .raddr (rp),
    .rdata (ring_rdata)
  );

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = req_valid && !req_stall;
  assign ring_full = (ptr_inc(wp) == rp);

  always_comb begin
    state_next          = state;
    res_next            = res;
    echo_enable_next    = echo_enable;
    canonical_mode_next = canonical_mode;
    end_pending_next    = end_pending;
    line_count_next     = line_count;
    dlen_next           = dlen;
    idx_next            = idx;
    pv_next             = pv;
    wp_next             = wp;
    rp_next             = rp;
    line_we             = 1'b0;
    line_waddr          = line_count;
    line_wdata          = req.key_byte;
    ring_we             = 1'b0;
    ring_wdata          = req.key_byte;

    if (cfg_valid) begin
      if (cfg_index == tld_pkg::CFG_ECHO) begin
        echo_enable_next = cfg_data;
      end else if (cfg_index == tld_pkg::CFG_CANON) begin
        if (cfg_data && !canonical_mode) begin
          line_count_next = '0;
        end
        canonical_mode_next = cfg_data;
      end
    end

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_next   = '0;
          state_next = S_EMIT;
          unique case (req.kind)
            tld_pkg::KIND_KEY: begin
              if (req.key_byte == tld_pkg::CH_ETX) begin
                res_next.signal_kind = tld_pkg::SIG_INT;
              end else if (req.key_byte == tld_pkg::CH_SUB) begin
                res_next.signal_kind = tld_pkg::SIG_STOP;
              end else if (!canonical_mode) begin
                if (!ring_full) begin
                  ring_we = 1'b1;
                  wp_next = ptr_inc(wp);
                end
                if (echo_enable) begin
                  if (req.key_byte == tld_pkg::CH_LF) begin
                    res_next.echo_kind = tld_pkg::ECHO_NL;
                  end else begin
                    res_next.echo_kind = tld_pkg::ECHO_BYTE;
                    res_next.echo_byte = req.key_byte;
                  end
                end
              end else begin
                priority case (req.key_byte)
                  tld_pkg::CH_CR, tld_pkg::CH_LF: begin
                    line_we         = 1'b1;
                    line_wdata      = tld_pkg::CH_LF;
                    dlen_next       = {1'b0, line_count} + 1'b1;
                    line_count_next = '0;
                    idx_next        = '0;
                    pv_next         = 1'b0;
                    state_next      = S_DLV;
                    if (echo_enable) begin
                      res_next.echo_kind = tld_pkg::ECHO_NL;
                    end
                  end
                  tld_pkg::CH_BS, tld_pkg::CH_DEL: begin
                    if (line_count != '0) begin
                      line_count_next = line_count - 1'b1;
                      if (echo_enable) begin
                        res_next.echo_kind   = tld_pkg::ECHO_ERASE;
                        res_next.erase_count = 7'd1;
                      end
                    end
                  end
                  tld_pkg::CH_NAK: begin
                    if (line_count != '0) begin
                      line_count_next = '0;
                      if (echo_enable) begin
                        res_next.echo_kind   = tld_pkg::ECHO_ERASE;
                        res_next.erase_count = erase_sat(line_count);
                      end
                    end
                  end
                  tld_pkg::CH_EOT: begin
                    if (line_count != '0) begin
                      dlen_next       = {1'b0, line_count};
                      line_count_next = '0;
                      idx_next        = '0;
                      pv_next         = 1'b0;
                      state_next      = S_DLV;
                    end else begin
                      end_pending_next = 1'b1;
                    end
                  end
                  default: begin
                    if ((req.key_byte >= tld_pkg::CH_SPACE ||
                         req.key_byte == tld_pkg::CH_TAB) &&
                        line_count < tld_pkg::LINE_AW'(tld_pkg::LINE_DEPTH - 1)) begin
                      line_we         = 1'b1;
                      line_count_next = line_count + 1'b1;
                      if (echo_enable) begin
                        res_next.echo_kind = tld_pkg::ECHO_BYTE;
                        res_next.echo_byte = req.key_byte;
                      end
                    end
                  end
                endcase
              end
            end
            tld_pkg::KIND_READ: begin
              if (rp != wp) begin
                rp_next             = ptr_inc(rp);
                res_next.read_valid = 1'b1;
                state_next          = S_READ;
              end else if (end_pending) begin
                end_pending_next      = 1'b0;
                res_next.end_of_input = 1'b1;
              end else begin
                res_next.ring_empty = 1'b1;
              end
            end
            tld_pkg::KIND_DISCARD: begin
              line_count_next  = '0;
              rp_next          = wp;
              end_pending_next = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        res_next.read_byte = ring_rdata;
        res_next.line_end  = canonical_mode && (ring_rdata == tld_pkg::CH_LF);
        state_next         = S_EMIT;
      end
      S_DLV: begin
        if (pv && ring_full) begin
          res_next.delivery_dropped = 1'b1;
          pv_next    = 1'b0;
          state_next = S_EMIT;
        end else begin
          if (pv) begin
            ring_we    = 1'b1;
            ring_wdata = line_rdata;
            wp_next    = ptr_inc(wp);
          end
          if (idx < dlen) begin
            idx_next = idx + 1'b1;
            pv_next  = 1'b1;
          end else begin
            pv_next = 1'b0;
            if (!pv) begin
              state_next = S_EMIT;
            end
          end
        end
      end
      S_EMIT: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      echo_enable    <= 1'b1;
      canonical_mode <= 1'b1;
      end_pending    <= 1'b0;
      line_count     <= '0;
      wp             <= '0;
      rp             <= '0;
      pv             <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      echo_enable    <= echo_enable_next;
      canonical_mode <= canonical_mode_next;
      end_pending    <= end_pending_next;
      line_count     <= line_count_next;
      wp             <= wp_next;
      rp             <= rp_next;
      pv             <= pv_next;
      if (state == S_EMIT && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res  <= res_next;
    dlen <= dlen_next;
    idx  <= idx_next;
    if (state == S_EMIT && (!rsp_valid || !rsp_stall)) begin
      rsp <= res;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tld_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module tld_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sim/tb_terminal_line_discipline_core.sv
// Self-checking testbench for terminal_line_discipline_core: directed and random requests
// with random idling on both sides, checked against an in-bench line editor model.
// Depends on tld_pkg and the core RTL only.
module tb_terminal_line_discipline_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [tld_pkg::CFG_IW-1:0] CFG_SPARE_A = tld_pkg::CFG_IW'(2);
  localparam logic [tld_pkg::CFG_IW-1:0] CFG_SPARE_B = tld_pkg::CFG_IW'(3);
  localparam int RANDOM_ITEMS = 150;
  localparam int PHASE_ITEMS  = 25;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 1000000;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         req_valid = 1'b0;
  logic                         req_stall;
  tld_pkg::tld_req_t            req = '0;
  logic                         rsp_valid;
  logic                         rsp_stall = 1'b0;
  tld_pkg::tld_rsp_t            rsp;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [tld_pkg::CFG_IW-1:0]   cfg_index = '0;
  logic                         cfg_data = 1'b0;

  terminal_line_discipline_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Line editor state as seen from outside
  logic [7:0] line_mem [tld_pkg::LINE_DEPTH];
  int         line_len;
  logic [7:0] ring_mem [tld_pkg::RING_DEPTH];
  int         ring_wr;
  int         ring_rd;
  bit         eof_pending;
  bit         echo_on = 1'b1;
  bit         canon_on = 1'b1;

  tld_pkg::tld_rsp_t reply_q [$];
  int         fail_count;
  int         reqs_sent;
  int         cycle_count;
  bit         calm;
  int         hold_tok;
  int         hold_seen;
  int         hold_left;

  function automatic tld_pkg::tld_rsp_t with_echo(tld_pkg::tld_rsp_t o, logic [1:0] k,
                                                  logic [7:0] b, int n);
    if (echo_on) begin
      o.echo_kind   = k;
      o.echo_byte   = b;
      o.erase_count = (n > 127) ? 7'd127 : 7'(n);
    end
    return o;
  endfunction

  function automatic bit ring_put(logic [7:0] b);
    int nxt;
    nxt = (ring_wr + 1) % tld_pkg::RING_DEPTH;
    if (nxt == ring_rd) return 1'b0;
    ring_mem[ring_wr] = b;
    ring_wr = nxt;
    return 1'b1;
  endfunction

  function automatic logic flush_line();
    logic lost;
    lost = 1'b0;
    for (int i = 0; i < line_len && !lost; i++) begin
      if (!ring_put(line_mem[i])) lost = 1'b1;
    end
    line_len = 0;
    return lost;
  endfunction

  function automatic tld_pkg::tld_rsp_t key_reply(logic [7:0] c);
    tld_pkg::tld_rsp_t o;
    o = '0;
    if (c == tld_pkg::CH_ETX) begin
      o.signal_kind = tld_pkg::SIG_INT;
    end else if (c == tld_pkg::CH_SUB) begin
      o.signal_kind = tld_pkg::SIG_STOP;
    end else if (!canon_on) begin
      void'(ring_put(c));
      o = (c == tld_pkg::CH_LF) ? with_echo(o, tld_pkg::ECHO_NL, 8'd0, 0)
                                : with_echo(o, tld_pkg::ECHO_BYTE, c, 0);
    end else begin
      case (c)
        tld_pkg::CH_CR, tld_pkg::CH_LF: begin
          if (line_len < tld_pkg::LINE_DEPTH) begin
            line_mem[line_len] = tld_pkg::CH_LF;
            line_len++;
          end
          o = with_echo(o, tld_pkg::ECHO_NL, 8'd0, 0);
          o.delivery_dropped = flush_line();
        end
        tld_pkg::CH_BS, tld_pkg::CH_DEL: begin
          if (line_len != 0) begin
            line_len--;
            o = with_echo(o, tld_pkg::ECHO_ERASE, 8'd0, 1);
          end
        end
        tld_pkg::CH_NAK: begin
          if (line_len != 0) begin
            o = with_echo(o, tld_pkg::ECHO_ERASE, 8'd0, line_len);
            line_len = 0;
          end
        end
        tld_pkg::CH_EOT: begin
          if (line_len != 0) o.delivery_dropped = flush_line();
          else eof_pending = 1'b1;
        end
        default: begin
          if ((c >= tld_pkg::CH_SPACE || c == tld_pkg::CH_TAB) &&
              line_len < tld_pkg::LINE_DEPTH - 1) begin
            line_mem[line_len] = c;
            line_len++;
            o = with_echo(o, tld_pkg::ECHO_BYTE, c, 0);
          end
        end
      endcase
    end
    return o;
  endfunction

  function automatic tld_pkg::tld_rsp_t tty_reply_for(tld_pkg::tld_req_t r);
    tld_pkg::tld_rsp_t o;
    o = '0;
    case (r.kind)
      tld_pkg::KIND_KEY: begin
        o = key_reply(r.key_byte);
      end
      tld_pkg::KIND_READ: begin
        if (ring_rd != ring_wr) begin
          o.read_valid = 1'b1;
          o.read_byte  = ring_mem[ring_rd];
          o.line_end   = canon_on && (ring_mem[ring_rd] == tld_pkg::CH_LF);
          ring_rd = (ring_rd + 1) % tld_pkg::RING_DEPTH;
        end else if (eof_pending) begin
          eof_pending = 1'b0;
          o.end_of_input = 1'b1;
        end else begin
          o.ring_empty = 1'b1;
        end
      end
      tld_pkg::KIND_DISCARD: begin
        line_len = 0;
        ring_rd = ring_wr;
        eof_pending = 1'b0;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic void tty_apply_cfg(logic [tld_pkg::CFG_IW-1:0] idx, logic d);
    if (idx == tld_pkg::CFG_ECHO) begin
      echo_on = d;
    end else if (idx == tld_pkg::CFG_CANON) begin
      if (d && !canon_on) line_len = 0;
      canon_on = d;
    end
  endfunction

  // Receiver: random stall, plus a long hold-off started by a token change
  always @(posedge clk) begin
    if (hold_tok != hold_seen) begin
      hold_seen <= hold_tok;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 28);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : rsp_check
    tld_pkg::tld_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (reply_q.size() == 0) begin
        $error("result with no request outstanding: %h", rsp);
        fail_count++;
      end else begin
        want = reply_q.pop_front();
        check_field("echo_kind", want.echo_kind, rsp.echo_kind);
        check_field("echo_byte", want.echo_byte, rsp.echo_byte);
        check_field("erase_count", want.erase_count, rsp.erase_count);
        check_field("signal_kind", want.signal_kind, rsp.signal_kind);
        check_field("delivery_dropped", want.delivery_dropped, rsp.delivery_dropped);
        check_field("read_valid", want.read_valid, rsp.read_valid);
        check_field("read_byte", want.read_byte, rsp.read_byte);
        check_field("line_end", want.line_end, rsp.line_end);
        check_field("end_of_input", want.end_of_input, rsp.end_of_input);
        check_field("ring_empty", want.ring_empty, rsp.ring_empty);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_req(input logic [1:0] k, input logic [7:0] b);
    tld_pkg::tld_req_t item;
    item.kind     = k;
    item.key_byte = b;
    while (!calm && $urandom_range(0, 99) < 28) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    reply_q.push_back(tty_reply_for(item));
    reqs_sent++;
  endtask

  task automatic press(input logic [7:0] b);
    send_req(tld_pkg::KIND_KEY, b);
  endtask

  task automatic read_one();
    send_req(tld_pkg::KIND_READ, 8'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (reply_q.size() != 0);
  endtask

  task automatic cfg_write(input logic [tld_pkg::CFG_IW-1:0] idx, input logic d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tty_apply_cfg(idx, d);
  endtask

  // Call only when idle, with at least one request since the last call
  task automatic cfg_group(input bit echo_v, input bit canon_v, input bit with_spare);
    cfg_write(tld_pkg::CFG_ECHO, echo_v);
    cfg_write(tld_pkg::CFG_CANON, canon_v);
    if (with_spare) begin
      cfg_write(CFG_SPARE_A, !echo_v);
      cfg_write(CFG_SPARE_B, !canon_v);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] printable();
    logic [7:0] b;
    b = 8'($urandom_range(32, 255));
    return (b == tld_pkg::CH_DEL) ? tld_pkg::CH_SPACE : b;
  endfunction

  function automatic logic [7:0] line_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return tld_pkg::CH_BS;
    if (r < 5) return tld_pkg::CH_DEL;
    if (r == 5) return tld_pkg::CH_NAK;
    if (r < 9) return tld_pkg::CH_TAB;
    if (r == 9) return ($urandom_range(0, 1) != 0) ? tld_pkg::CH_ETX : tld_pkg::CH_SUB;
    if (r == 10) return 8'($urandom_range(0, 31));
    return printable();
  endfunction

  task automatic test_keys();
    press(8'h61);
    press(8'h80);
    press(8'hFF);
    press(tld_pkg::CH_TAB);
    press(8'h01);
    press(tld_pkg::CH_ETX);
    press(tld_pkg::CH_SUB);
    press(tld_pkg::CH_BS);
    press(tld_pkg::CH_DEL);
    press(tld_pkg::CH_NAK);
    press(tld_pkg::CH_NAK);
    press(tld_pkg::CH_BS);
    press(tld_pkg::CH_EOT);
    read_one();
    read_one();
    send_req(KIND_UNUSED, 8'hFF);
    press(tld_pkg::CH_SPACE);
    press(8'h7E);
    press(tld_pkg::CH_EOT);
    read_one();
    read_one();
    press(8'h00);
    press(tld_pkg::CH_CR);
    read_one();
    read_one();
    press(tld_pkg::CH_LF);
    read_one();
    press(tld_pkg::CH_EOT);
    press(8'h71);
    send_req(tld_pkg::KIND_DISCARD, 8'h00);
    read_one();
  endtask

  task automatic test_echo_off();
    drain();
    cfg_group(1'b0, 1'b1, 1'b0);
    press(8'h41);
    press(tld_pkg::CH_TAB);
    press(tld_pkg::CH_BS);
    press(8'h42);
    press(tld_pkg::CH_NAK);
    press(8'h43);
    press(tld_pkg::CH_CR);
    press(tld_pkg::CH_ETX);
    read_one();
    read_one();
    drain();
    cfg_group(1'b1, 1'b1, 1'b0);
    press(8'h44);
  endtask

  task automatic test_raw();
    logic [7:0] b;
    press(8'h61);
    press(8'h62);
    drain();
    cfg_group(1'b1, 1'b0, 1'b0);
    press(8'h72);
    press(tld_pkg::CH_LF);
    press(tld_pkg::CH_ETX);
    press(8'h00);
    press(8'hFF);
    press(tld_pkg::CH_BS);
    press(tld_pkg::CH_SUB);
    repeat (7) read_one();
    // raw overflow drops silently
    repeat (260) begin
      b = 8'($urandom_range(0, 255));
      press(b);
    end
    repeat (256) read_one();
    drain();
    cfg_group(1'b0, 1'b0, 1'b0);
    press(tld_pkg::CH_LF);
    press(8'h5A);
    read_one();
    drain();
    cfg_group(1'b1, 1'b1, 1'b0);
    press(tld_pkg::CH_CR);
    read_one();
    read_one();
  endtask

  task automatic test_line_full();
    repeat (130) press(printable());
    press(tld_pkg::CH_NAK);
    repeat (127) press(printable());
    press(tld_pkg::CH_CR);
    repeat (127) press(printable());
    press(tld_pkg::CH_LF);
    press(tld_pkg::CH_CR);
    repeat (5) press(printable());
    press(tld_pkg::CH_EOT);
    repeat (256) read_one();
    press(tld_pkg::CH_EOT);
    read_one();
  endtask

  task automatic test_spare_regs();
    drain();
    cfg_group(1'b1, 1'b1, 1'b1);
    press(8'h30);
    press(tld_pkg::CH_CR);
    read_one();
    drain();
    cfg_group(1'b0, 1'b0, 1'b1);
    press(8'h31);
    read_one();
    drain();
    cfg_group(1'b1, 1'b1, 1'b0);
    press(8'h32);
  endtask

  task automatic test_backpressure();
    drain();
    hold_tok <= hold_tok + 1;
    repeat (12) press(printable());
    press(tld_pkg::CH_CR);
    repeat (15) read_one();
    drain();
    repeat (4) press(printable());
    press(tld_pkg::CH_EOT);
    repeat (6) read_one();
  endtask

  task automatic random_burst();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 140) : $urandom_range(0, 12);
      repeat (len) press(line_key());
      case ($urandom_range(0, 9))
        0, 1: press(tld_pkg::CH_EOT);
        2: press(tld_pkg::CH_NAK);
        3, 4, 5: press(tld_pkg::CH_CR);
        default: press(tld_pkg::CH_LF);
      endcase
      repeat ($urandom_range(0, len + 3)) read_one();
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 8)) read_one();
    end else begin
      repeat ($urandom_range(1, 4))
        send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random();
    int base;
    int phase;
    int phase_end;
    base  = reqs_sent;
    phase = 0;
    while (phase < 3 || reqs_sent - base < RANDOM_ITEMS) begin
      drain();
      calm <= (phase == 1 || phase == 2);
      cfg_group($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0, 1'b0);
      phase_end = reqs_sent + PHASE_ITEMS;
      while (reqs_sent < phase_end) random_burst();
      phase++;
    end
    calm <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_keys();
    test_echo_off();
    test_raw();
    test_line_full();
    test_spare_regs();
    test_backpressure();
    test_random();
    drain();
    repeat (140) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tld_pkg.sv
rtl/tld_ram.sv
rtl/terminal_line_discipline_core.sv
sim/tb_terminal_line_discipline_core.sv
